[design/trpd_pkg.sv]
// Shared types and constants for the TGA RLE pixel decoder.
// Request/response payloads, the front-to-back job record and the header codes.
package trpd_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] dest_row;
    logic [15:0] dest_col;
    logic        last;
  } rsp_t;

  // Work handed from the parser to the formatter.
  typedef struct packed {
    logic [1:0]      status;
    logic [3:0][7:0] pix;
    logic            has_alpha;
    logic [15:0]     row;
    logic [15:0]     col;
    logic [15:0]     width;
    logic [15:0]     height;
    logic [1:0]      orient;
    logic            last;
  } job_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_IDSKIP = 5'b00010,
    PH_PKTHDR = 5'b00100,
    PH_PIXEL  = 5'b01000,
    PH_RUN    = 5'b10000
  } phase_t;

  localparam logic [1:0] ST_PIXEL    = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_RUN_BUSY = 2'd3;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH    = 5'd16;
  localparam logic [4:0] HDR_DESC     = 5'd17;

  localparam logic [7:0] TYPE_RAW  = 8'd2;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [7:0] PKT_COUNT_MASK = 8'h7f;
  localparam int         PKT_REPEAT_BIT = 7;
  localparam int         DESC_TOP_BIT   = 5;
  localparam int         DESC_RIGHT_BIT = 4;

endpackage

[design/tga_rle_pixel_decoder.sv]
// TGA truecolor/RLE pixel decoder, one request per cycle sustained while rsp is not stalled.
// A pixel or error passes through the job queue and then the output register before it appears on rsp.
// Requests are taken one per cycle while the two-entry job queue has space; it fills only under rsp stall.
// Reset clears the parser to the header phase and empties queue and output register.
// Uses trpd_pkg, trpd_front, trpd_queue and trpd_back.
module tga_rle_pixel_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  trpd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output trpd_pkg::rsp_t rsp
);
  import trpd_pkg::*;

  logic job_valid;
  job_t job;
  logic space;
  logic pop;
  logic head_valid;
  job_t head;

  trpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .space     (space),
    .job_valid (job_valid),
    .job       (job)
  );

  trpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .space      (space),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  trpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

[design/trpd_front.sv]
// Front end of the TGA decoder: header parser, ID skip and RLE packet tracking.
// Produces one job per pixel or error into the queue. Uses trpd_pkg.
module trpd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  trpd_pkg::req_t req,
  input  logic          space,
  output logic          job_valid,
  output trpd_pkg::job_t job
);
  import trpd_pkg::*;

  phase_t          phase, phase_next;
  logic [4:0]      header_count, header_count_next;
  logic [7:0]      id_skip_left, id_skip_left_next;
  logic            is_compressed, is_compressed_next;
  logic [15:0]     image_width, image_width_next;
  logic [15:0]     image_height, image_height_next;
  logic            has_alpha, has_alpha_next;
  logic [1:0]      orient_bits, orient_bits_next;
  logic [7:0]      packet_left, packet_left_next;
  logic            packet_repeat, packet_repeat_next;
  logic [1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [3:0][7:0] pixel_bytes, pixel_bytes_next;
  logic [15:0]     file_row, file_row_next;
  logic [15:0]     file_col, file_col_next;
  logic [7:0]      hdr_type, hdr_type_next;
  logic [7:0]      hdr_depth, hdr_depth_next;

  logic       accept;
  logic       emit;
  logic       col_end;
  logic       last_pos;
  logic [7:0] b;
  logic [7:0] pkt_dec;

  assign req_ready = space;
  assign accept    = req_valid && req_ready;
  assign b         = req.data_byte;
  assign col_end   = ({1'b0, file_col} + 17'd1) >= {1'b0, image_width};
  assign last_pos  = (({1'b0, file_row} + 17'd1) == {1'b0, image_height}) &&
                     (({1'b0, file_col} + 17'd1) == {1'b0, image_width});
  assign pkt_dec   = packet_left - 8'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    id_skip_left_next  = id_skip_left;
    is_compressed_next = is_compressed;
    image_width_next   = image_width;
    image_height_next  = image_height;
    has_alpha_next     = has_alpha;
    orient_bits_next   = orient_bits;
    packet_left_next   = packet_left;
    packet_repeat_next = packet_repeat;
    byte_in_pixel_next = byte_in_pixel;
    pixel_bytes_next   = pixel_bytes;
    file_row_next      = file_row;
    file_col_next      = file_col;
    hdr_type_next      = hdr_type;
    hdr_depth_next     = hdr_depth;
    emit               = 1'b0;
    job_valid          = 1'b0;
    job                = '0;

    if (accept) begin
      if (req.action == ACT_DRAIN) begin
        if (phase == PH_RUN && packet_left != 8'd0) begin
          packet_left_next = pkt_dec;
          emit             = 1'b1;
          if (pkt_dec == 8'd0) phase_next = PH_PKTHDR;
        end
      end else begin
        case (phase)
          PH_HEADER: begin
            case (header_count)
              HDR_ID_LEN:    id_skip_left_next = b;
              HDR_TYPE:      hdr_type_next = b;
              HDR_WIDTH_LO:  image_width_next = {image_width[15:8], b};
              HDR_WIDTH_HI:  image_width_next = {b, image_width[7:0]};
              HDR_HEIGHT_LO: image_height_next = {image_height[15:8], b};
              HDR_HEIGHT_HI: image_height_next = {b, image_height[7:0]};
              HDR_DEPTH:     hdr_depth_next = b;
              default: ;
            endcase
            if (header_count < HDR_DESC) begin
              header_count_next = header_count + 5'd1;
            end else begin
              orient_bits_next  = {b[DESC_TOP_BIT], b[DESC_RIGHT_BIT]};
              header_count_next = '0;
              if (hdr_type != TYPE_RAW && hdr_type != TYPE_RLE) begin
                job_valid  = 1'b1;
                job.status = ST_BAD_TYPE;
              end else if (image_width == 16'd0 || image_height == 16'd0 ||
                           (hdr_depth != DEPTH_24 && hdr_depth != DEPTH_32)) begin
                job_valid  = 1'b1;
                job.status = ST_BAD_SIZE;
              end else begin
                is_compressed_next = (hdr_type == TYPE_RLE);
                has_alpha_next     = (hdr_depth == DEPTH_32);
                if (id_skip_left != 8'd0) begin
                  phase_next = PH_IDSKIP;
                end else begin
                  byte_in_pixel_next = '0;
                  packet_left_next   = '0;
                  packet_repeat_next = 1'b0;
                  file_row_next      = '0;
                  file_col_next      = '0;
                  phase_next = (hdr_type == TYPE_RLE) ? PH_PKTHDR : PH_PIXEL;
                end
              end
            end
          end
          PH_IDSKIP: begin
            id_skip_left_next = id_skip_left - 8'd1;
            if (id_skip_left == 8'd1) begin
              byte_in_pixel_next = '0;
              packet_left_next   = '0;
              packet_repeat_next = 1'b0;
              file_row_next      = '0;
              file_col_next      = '0;
              phase_next = is_compressed ? PH_PKTHDR : PH_PIXEL;
            end
          end
          PH_PKTHDR: begin
            packet_left_next   = (b & PKT_COUNT_MASK) + 8'd1;
            packet_repeat_next = b[PKT_REPEAT_BIT];
            byte_in_pixel_next = '0;
            phase_next         = PH_PIXEL;
          end
          PH_PIXEL: begin
            pixel_bytes_next[byte_in_pixel] = b;
            if (has_alpha ? (byte_in_pixel != 2'd3) : (byte_in_pixel != 2'd2)) begin
              byte_in_pixel_next = byte_in_pixel + 2'd1;
            end else begin
              byte_in_pixel_next = '0;
              emit               = 1'b1;
              if (is_compressed) begin
                if (packet_left != 8'd0) packet_left_next = pkt_dec;
                if (packet_left == 8'd0 || pkt_dec == 8'd0) phase_next = PH_PKTHDR;
                else if (packet_repeat) phase_next = PH_RUN;
              end
            end
          end
          PH_RUN: begin
            job_valid  = 1'b1;
            job.status = ST_RUN_BUSY;
          end
          default: begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
          end
        endcase
      end

      if (emit) begin
        job_valid     = 1'b1;
        job.status    = ST_PIXEL;
        job.pix       = pixel_bytes_next;
        job.has_alpha = has_alpha;
        job.row       = file_row;
        job.col       = file_col;
        job.width     = image_width;
        job.height    = image_height;
        job.orient    = orient_bits;
        job.last      = last_pos;
        if (last_pos) begin
          phase_next         = PH_HEADER;
          header_count_next  = '0;
          packet_left_next   = '0;
          packet_repeat_next = 1'b0;
          byte_in_pixel_next = '0;
          file_row_next      = '0;
          file_col_next      = '0;
        end else if (col_end) begin
          file_col_next = '0;
          file_row_next = file_row + 16'd1;
        end else begin
          file_col_next = file_col + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= '0;
      id_skip_left  <= '0;
      is_compressed <= 1'b0;
      image_width   <= '0;
      image_height  <= '0;
      has_alpha     <= 1'b0;
      orient_bits   <= '0;
      packet_left   <= '0;
      packet_repeat <= 1'b0;
      byte_in_pixel <= '0;
      pixel_bytes   <= '0;
      file_row      <= '0;
      file_col      <= '0;
      hdr_type      <= '0;
      hdr_depth     <= '0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      id_skip_left  <= id_skip_left_next;
      is_compressed <= is_compressed_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      has_alpha     <= has_alpha_next;
      orient_bits   <= orient_bits_next;
      packet_left   <= packet_left_next;
      packet_repeat <= packet_repeat_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_bytes   <= pixel_bytes_next;
      file_row      <= file_row_next;
      file_col      <= file_col_next;
      hdr_type      <= hdr_type_next;
      hdr_depth     <= hdr_depth_next;
    end
  end

  a_run_has_pixels: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RUN |-> packet_left != 8'd0)
    else $error("run phase with empty packet");

  a_last_returns_header: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.status == ST_PIXEL && job.last |=>
      phase == PH_HEADER && header_count == 5'd0)
    else $error("final pixel did not restart header parse");

endmodule

[design/trpd_queue.sv]
// Two-entry job queue between the parser and the pixel formatter.
// Uses trpd_pkg for the job record.
module trpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trpd_pkg::job_t push_job,
  output logic           space,
  input  logic           pop,
  output logic           head_valid,
  output trpd_pkg::job_t head
);
  import trpd_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign space      = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("queue underflow");

endmodule

[design/trpd_back.sv]
// Back end of the TGA decoder: maps a job to colors and destination position.
// Holds the response in an output register. Uses trpd_pkg.
module trpd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  trpd_pkg::job_t head,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output trpd_pkg::rsp_t rsp
);
  import trpd_pkg::*;

  rsp_t fmt;

  assign pop = head_valid && (!rsp_valid || rsp_ready);

  always_comb begin
    fmt = '0;
    fmt.status = head.status;
    if (head.status == ST_PIXEL) begin
      fmt.red      = head.pix[2];
      fmt.green    = head.pix[1];
      fmt.blue     = head.pix[0];
      fmt.alpha    = head.has_alpha ? head.pix[3] : ALPHA_OPAQUE;
      fmt.dest_row = head.orient[1] ? head.row : (head.height - 16'd1 - head.row);
      fmt.dest_col = head.orient[0] ? (head.width - 16'd1 - head.col) : head.col;
      fmt.last     = head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rsp <= fmt;
  end

endmodule

[dv/tga_rle_pixel_decoder_tb.sv]
// Testbench for tga_rle_pixel_decoder: streams TGA headers and raw and RLE pixel data
// through the request channel and checks each response against an in-bench decoder.
// Depends on trpd_pkg and the decoder RTL.
module tga_rle_pixel_decoder_tb;
  import trpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  tga_rle_pixel_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int effective_items = 0;
  int unsigned cycle_count = 0;
  rsp_t expected_pixels[$];

  // decoder state as seen from the byte stream
  phase_t          stage;
  logic [4:0]      hdr_index;
  logic [7:0]      id_left;
  logic [7:0]      hdr_kind;
  logic [7:0]      hdr_bpp;
  logic            rle_mode;
  logic            with_alpha;
  logic [15:0]     img_w;
  logic [15:0]     img_h;
  logic [1:0]      flip_bits;
  logic [7:0]      run_left;
  logic            run_is_repeat;
  logic [1:0]      byte_pos;
  logic [3:0][7:0] px;
  logic [15:0]     cur_row;
  logic [15:0]     cur_col;

  function automatic void reset_decoder_state();
    stage = PH_HEADER;
    hdr_index = '0;
    id_left = '0;
    hdr_kind = '0;
    hdr_bpp = '0;
    rle_mode = 1'b0;
    with_alpha = 1'b0;
    img_w = '0;
    img_h = '0;
    flip_bits = '0;
    run_left = '0;
    run_is_repeat = 1'b0;
    byte_pos = '0;
    px = '0;
    cur_row = '0;
    cur_col = '0;
  endfunction

  function automatic void begin_body();
    byte_pos = '0;
    run_left = '0;
    run_is_repeat = 1'b0;
    cur_row = '0;
    cur_col = '0;
    stage = rle_mode ? PH_PKTHDR : PH_PIXEL;
  endfunction

  function automatic rsp_t place_pixel();
    rsp_t p;
    p = '0;
    p.status = ST_PIXEL;
    p.red = px[2];
    p.green = px[1];
    p.blue = px[0];
    p.alpha = with_alpha ? px[3] : ALPHA_OPAQUE;
    p.dest_row = flip_bits[1] ? cur_row : img_h - 16'd1 - cur_row;
    p.dest_col = flip_bits[0] ? img_w - 16'd1 - cur_col : cur_col;
    p.last = ({1'b0, cur_row} + 17'd1 == {1'b0, img_h}) &&
             ({1'b0, cur_col} + 17'd1 == {1'b0, img_w});
    if (p.last) begin
      stage = PH_HEADER;
      hdr_index = '0;
      run_left = '0;
      run_is_repeat = 1'b0;
      byte_pos = '0;
      cur_row = '0;
      cur_col = '0;
    end else if ({1'b0, cur_col} + 17'd1 >= {1'b0, img_w}) begin
      cur_col = '0;
      cur_row = cur_row + 16'd1;
    end else begin
      cur_col = cur_col + 16'd1;
    end
    return p;
  endfunction

  function automatic void push_error(logic [1:0] code);
    rsp_t p;
    p = '0;
    p.status = code;
    expected_pixels.push_back(p);
  endfunction

  function automatic void decode_request(req_t r);
    logic [7:0] b;
    rsp_t p;
    int need;
    b = r.data_byte;
    if (r.action == ACT_DRAIN) begin
      if (stage != PH_RUN || run_left == 0) return;
      run_left = run_left - 8'd1;
      p = place_pixel();
      if (!p.last && run_left == 0) stage = PH_PKTHDR;
      expected_pixels.push_back(p);
      return;
    end
    case (stage)
      PH_HEADER: begin
        case (hdr_index)
          HDR_ID_LEN:    id_left = b;
          HDR_TYPE:      hdr_kind = b;
          HDR_WIDTH_LO:  img_w[7:0] = b;
          HDR_WIDTH_HI:  img_w[15:8] = b;
          HDR_HEIGHT_LO: img_h[7:0] = b;
          HDR_HEIGHT_HI: img_h[15:8] = b;
          HDR_DEPTH:     hdr_bpp = b;
          default: ;
        endcase
        if (hdr_index < HDR_DESC) begin
          hdr_index = hdr_index + 5'd1;
          return;
        end
        flip_bits = {b[DESC_TOP_BIT], b[DESC_RIGHT_BIT]};
        hdr_index = '0;
        if (hdr_kind != TYPE_RAW && hdr_kind != TYPE_RLE) begin
          push_error(ST_BAD_TYPE);
          return;
        end
        if (img_w == 0 || img_h == 0 || (hdr_bpp != DEPTH_24 && hdr_bpp != DEPTH_32)) begin
          push_error(ST_BAD_SIZE);
          return;
        end
        rle_mode = (hdr_kind == TYPE_RLE);
        with_alpha = (hdr_bpp == DEPTH_32);
        if (id_left != 0) stage = PH_IDSKIP;
        else begin_body();
      end
      PH_IDSKIP: begin
        id_left = id_left - 8'd1;
        if (id_left == 0) begin_body();
      end
      PH_PKTHDR: begin
        run_left = (b & PKT_COUNT_MASK) + 8'd1;
        run_is_repeat = b[PKT_REPEAT_BIT];
        byte_pos = '0;
        stage = PH_PIXEL;
      end
      PH_PIXEL: begin
        need = with_alpha ? 4 : 3;
        px[byte_pos] = b;
        if (int'(byte_pos) + 1 < need) begin
          byte_pos = byte_pos + 2'd1;
          return;
        end
        byte_pos = '0;
        if (!rle_mode) begin
          expected_pixels.push_back(place_pixel());
          return;
        end
        if (run_left != 0) run_left = run_left - 8'd1;
        p = place_pixel();
        if (!p.last) begin
          if (run_left == 0) stage = PH_PKTHDR;
          else if (run_is_repeat) stage = PH_RUN;
        end
        expected_pixels.push_back(p);
      end
      PH_RUN: push_error(ST_RUN_BUSY);
      default: begin
        stage = PH_HEADER;
        hdr_index = '0;
      end
    endcase
  endfunction

  always @(posedge clk) rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: response expected none got status %0d", $time, rsp.status);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("status", 16'(want.status), 16'(rsp.status));
        check_field("red", 16'(want.red), 16'(rsp.red));
        check_field("green", 16'(want.green), 16'(rsp.green));
        check_field("blue", 16'(want.blue), 16'(rsp.blue));
        check_field("alpha", 16'(want.alpha), 16'(rsp.alpha));
        check_field("dest_row", want.dest_row, rsp.dest_row);
        check_field("dest_col", want.dest_col, rsp.dest_col);
        check_field("last", 16'(want.last), 16'(rsp.last));
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_req(input logic act, input logic [7:0] b);
    req_t item;
    item.action = act;
    item.data_byte = b;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    if (act == ACT_BYTE || stage == PH_RUN) effective_items++;
    decode_request(item);
  endtask

  task automatic send_pixel(input int nbytes);
    repeat (nbytes) send_req(ACT_BYTE, 8'($urandom));
  endtask

  task automatic send_header(input logic [7:0] kind, input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] bpp, input logic [7:0] desc,
                             input logic [7:0] id_len);
    logic [7:0] hdr [18];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[HDR_ID_LEN] = id_len;
    hdr[HDR_TYPE] = kind;
    hdr[HDR_WIDTH_LO] = w[7:0];
    hdr[HDR_WIDTH_HI] = w[15:8];
    hdr[HDR_HEIGHT_LO] = h[7:0];
    hdr[HDR_HEIGHT_HI] = h[15:8];
    hdr[HDR_DEPTH] = bpp;
    hdr[HDR_DESC] = desc;
    foreach (hdr[i]) send_req(ACT_BYTE, hdr[i]);
    if (stage == PH_IDSKIP) repeat (id_len) send_req(ACT_BYTE, 8'($urandom));
  endtask

  // noisy: stray bytes inside runs (stray drains outside runs are sent by send_image)
  // a repeat packet past the image end gets one drain beyond the last pixel
  task automatic send_packet(input bit rep, input int count, input int nbytes, input int used,
                             input bit noisy);
    send_req(ACT_BYTE, {rep, 7'(count - 1)});
    if (!rep) begin
      repeat (used) send_pixel(nbytes);
      return;
    end
    send_pixel(nbytes);
    repeat (((count > used) ? used + 1 : count) - 1) begin
      if (noisy && stage == PH_RUN && $urandom_range(0, 5) == 0)
        send_req(ACT_BYTE, 8'($urandom));
      send_req(ACT_DRAIN, 8'($urandom));
    end
  endtask

  task automatic send_image(input logic [7:0] kind, input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] bpp, input logic [7:0] desc,
                            input logic [7:0] id_len, input int pixels, input bit noisy);
    int nbytes;
    int left;
    int count;
    int used;
    bit rep;
    send_header(kind, w, h, bpp, desc, id_len);
    if (stage == PH_HEADER) return;
    nbytes = (bpp == DEPTH_32) ? 4 : 3;
    left = pixels;
    if (kind == TYPE_RAW) begin
      repeat (left) send_pixel(nbytes);
      return;
    end
    while (left > 0) begin
      rep = 1'($urandom_range(0, 1));
      if (left <= 128 && $urandom_range(0, 15) == 0) count = $urandom_range(left, 128);
      else count = $urandom_range(1, (left < 6) ? left : 6);
      used = (count < left) ? count : left;
      send_packet(rep, count, nbytes, used, noisy);
      left -= used;
      if (noisy && stage != PH_RUN && $urandom_range(0, 7) == 0)
        send_req(ACT_DRAIN, 8'($urandom));
    end
  endtask

  task automatic test_header_rejects();
    set_idling(0, 0);
    send_image(8'd0, 16'd2, 16'd2, DEPTH_24, 8'h00, 8'd0, 4, 1'b0);
    send_image(8'd1, 16'd2, 16'd2, DEPTH_24, 8'h00, 8'd3, 4, 1'b0);
    send_image(8'd255, 16'd1, 16'd1, DEPTH_32, 8'hff, 8'd0, 1, 1'b0);
    send_image(8'd0, 16'd0, 16'd0, 8'd0, 8'h00, 8'd0, 0, 1'b0);
    send_image(TYPE_RAW, 16'hffff, 16'd0, DEPTH_24, 8'h00, 8'd0, 0, 1'b0);
    send_image(TYPE_RLE, 16'd0, 16'hffff, DEPTH_32, 8'h00, 8'd0, 0, 1'b0);
    send_image(TYPE_RLE, 16'd1, 16'd1, 8'd255, 8'h00, 8'd0, 1, 1'b0);
  endtask

  task automatic test_raw_orientation();
    logic [7:0] descs [4] = '{8'h00, 8'h10, 8'h20, 8'h30};
    set_idling(0, 0);
    foreach (descs[i])
      send_image(TYPE_RAW, 16'd2, 16'd2, (i % 2) ? DEPTH_32 : DEPTH_24, descs[i], 8'd0, 4, 1'b0);
    send_image(TYPE_RAW, 16'd1, 16'd2, DEPTH_32, 8'hff, 8'd7, 2, 1'b0);
  endtask

  task automatic test_rle_runs();
    set_idling(24, 24);
    // one repeat packet covers the whole image
    send_header(TYPE_RLE, 16'd8, 16'd4, DEPTH_32, 8'h20, 8'd0);
    send_packet(1'b1, 32, 4, 32, 1'b0);
    // literal packet longer than the image
    send_header(TYPE_RLE, 16'd2, 16'd2, DEPTH_24, 8'h10, 8'd0);
    send_packet(1'b0, 128, 3, 4, 1'b0);
    // stray drain, byte during a run, single-pixel repeat packet
    send_header(TYPE_RLE, 16'd2, 16'd2, DEPTH_24, 8'h00, 8'd0);
    send_req(ACT_DRAIN, 8'hff);
    send_req(ACT_BYTE, {1'b1, 7'd2});
    send_pixel(3);
    send_req(ACT_BYTE, 8'ha5);
    send_req(ACT_DRAIN, 8'h00);
    send_req(ACT_DRAIN, 8'h00);
    send_packet(1'b1, 1, 3, 1, 1'b0);
    send_req(ACT_DRAIN, 8'h00);
    // longest repeat packet running past the last pixel
    send_header(TYPE_RLE, 16'd3, 16'd1, DEPTH_32, 8'h30, 8'd0);
    send_packet(1'b1, 128, 4, 3, 1'b0);
  endtask

  task automatic send_random_file();
    logic [7:0] kind;
    logic [7:0] bpp;
    logic [15:0] w;
    logic [15:0] h;
    int pick;
    pick = $urandom_range(0, 19);
    kind = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
    w = 16'($urandom_range(1, 5));
    h = 16'($urandom_range(1, 4));
    bpp = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
    if (pick == 0) kind = 8'($urandom);
    else if (pick == 1) begin
      if ($urandom_range(0, 1)) w = '0;
      else h = '0;
    end else if (pick == 2) bpp = 8'($urandom);
    send_image(kind, w, h, bpp, 8'($urandom), 8'($urandom_range(0, 4)),
               int'(w) * int'(h), 1'b1);
  endtask

  task automatic test_random_files();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(61, 0);
        2: set_idling(0, 61);
        default: set_idling(24, 24);
      endcase
      target = effective_items + 25;
      while (effective_items < target) send_random_file();
    end
  endtask

  // never completes, so it has to come last
  task automatic test_huge_frame();
    set_idling(24, 24);
    send_image(TYPE_RLE, 16'hffff, 16'hffff, DEPTH_24, 8'h10, 8'd0, 8, 1'b1);
  endtask

  initial begin
    reset_decoder_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_header_rejects();
    test_raw_orientation();
    test_rle_runs();
    test_random_files();
    test_huge_frame();
    req_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[tga_rle_pixel_decoder.f]
design/trpd_pkg.sv
design/trpd_front.sv
design/trpd_queue.sv
design/trpd_back.sv
design/tga_rle_pixel_decoder.sv
dv/tga_rle_pixel_decoder_tb.sv
